[hdl/tlco_pkg.sv]
package tlco_pkg;

    // Angle resolution kept from the phase and number of CORDIC rotations
    localparam int ANGLE_BITS    = 24;
    localparam int CORDIC_STAGES = 24;

    // Field widths
    localparam int TIME_W     = 48;
    localparam int RAD_W      = 40;
    localparam int SPD_W      = 24;
    localparam int RATE_W     = 64;
    localparam int POS_W      = 48;
    localparam int VEL_W      = 32;
    localparam int BODY_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    // Internal datapath widths
    localparam int ANG_W  = 32;  // one turn is 2^32
    localparam int CW     = 33;  // CORDIC x, y, z
    localparam int MAG_W  = 32;  // magnitude of a Q30 cos or sin
    localparam int LPOS_W = 43;  // signed lane position
    localparam int LVEL_W = 27;  // signed lane velocity

    // Lane pipeline: two phase stages, the rotations, then fold, multiply,
    // round and sign stages
    localparam int LANE_LAT = CORDIC_STAGES + 6;

    localparam logic [ANG_W-1:0] ANGLE_MASK =
        ~((ANG_W'(1) << (ANG_W - ANGLE_BITS)) - ANG_W'(1));

    localparam logic signed [CW-1:0] GAIN_Q30 = 33'sd652032874;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PLANET_RADIUS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PLANET_SPEED  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PLANET_RATE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MOON_RADIUS   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MOON_SPEED    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MOON_RATE     = 3'd5;

    typedef enum logic [BODY_W-1:0] {
        BODY_SUN    = 2'd0,
        BODY_PLANET = 2'd1,
        BODY_MOON   = 2'd2
    } t_body;

    typedef struct packed {
        logic [RAD_W-1:0]  radius;
        logic [SPD_W-1:0]  speed;
        logic [RATE_W-1:0] rate;
    } t_lane_cfg;

    typedef struct packed {
        logic signed [LPOS_W-1:0] pos_x;
        logic signed [LPOS_W-1:0] pos_y;
        logic signed [LVEL_W-1:0] vel_x;
        logic signed [LVEL_W-1:0] vel_y;
    } t_orbit;

    typedef struct packed {
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [VEL_W-1:0] vel_x;
        logic signed [VEL_W-1:0] vel_y;
    } t_result;

    // Arctangent of 2^-i in units of 2^-32 turn
    function automatic logic [ANG_W-1:0] atan_turn(input int idx);
        logic [ANG_W-1:0] v;
        case (idx)
            0:  v = 32'h20000000;
            1:  v = 32'h12E4051D;
            2:  v = 32'h09FB385B;
            3:  v = 32'h051111D4;
            4:  v = 32'h028B0D43;
            5:  v = 32'h0145D7E1;
            6:  v = 32'h00A2F61E;
            7:  v = 32'h00517C55;
            8:  v = 32'h0028BE53;
            9:  v = 32'h00145F2F;
            10: v = 32'h000A2F98;
            11: v = 32'h000517CC;
            12: v = 32'h00028BE6;
            13: v = 32'h000145F3;
            14: v = 32'h0000A2F9;
            15: v = 32'h0000517C;
            16: v = 32'h000028BE;
            17: v = 32'h0000145F;
            18: v = 32'h00000A2F;
            19: v = 32'h00000517;
            20: v = 32'h0000028B;
            21: v = 32'h00000145;
            22: v = 32'h000000A2;
            23: v = 32'h00000051;
            24: v = 32'h00000028;
            25: v = 32'h00000014;
            26: v = 32'h0000000A;
            27: v = 32'h00000005;
            28: v = 32'h00000002;
            29: v = 32'h00000001;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

[hdl/tlco_in_if.sv]
interface tlco_in_if import tlco_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [TIME_W-1:0] elapsed_time;

    modport source (output valid, output elapsed_time, input ready);
    modport sink   (input valid, input elapsed_time, output ready);
endinterface

[hdl/tlco_out_if.sv]
interface tlco_out_if import tlco_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [BODY_W-1:0]       body;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [VEL_W-1:0] vel_x;
    logic signed [VEL_W-1:0] vel_y;
    logic                    last;

    modport source (output valid, output body, output pos_x, output pos_y,
                    output vel_x, output vel_y, output last, input ready);
    modport sink   (input valid, input body, input pos_x, input pos_y,
                    input vel_x, input vel_y, input last, output ready);
endinterface

[hdl/two_level_circular_orbit_generator_unit.sv]
// Channel  Dir  Payload                                   Handshake
// i_in     in   elapsed_time                              valid / ready
// o_out    out  body, pos_x, pos_y, vel_x, vel_y, last    valid / ready
// i_cfg_*  in   i_cfg_idx, i_cfg_data                     i_cfg_we, no wait
//
// Each item yields three result items (sun, planet, moon), one per cycle while the
// output is ready, so the sustained rate is set by the output port.
// An item can enter the lane pipeline in any cycle in which its tail moves; the
// sun item appears after the lane stages and the output register.
// Reset is synchronous, active low; it clears the config registers, valid bits and body state.
// A stall on the output freezes the whole pipeline once its last stage is full.
module two_level_circular_orbit_generator_unit import tlco_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    tlco_in_if.sink               i_in,
    tlco_out_if.source            o_out
);

    localparam int TAIL = LANE_LAT - 1;

    // Configuration registers
    t_lane_cfg r_planet_cfg;
    t_lane_cfg r_moon_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_planet_cfg <= '0;
            r_moon_cfg   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_PLANET_RADIUS: r_planet_cfg.radius <= i_cfg_data[RAD_W-1:0];
                CFG_PLANET_SPEED:  r_planet_cfg.speed  <= i_cfg_data[SPD_W-1:0];
                CFG_PLANET_RATE:   r_planet_cfg.rate   <= i_cfg_data[RATE_W-1:0];
                CFG_MOON_RADIUS:   r_moon_cfg.radius   <= i_cfg_data[RAD_W-1:0];
                CFG_MOON_SPEED:    r_moon_cfg.speed    <= i_cfg_data[SPD_W-1:0];
                CFG_MOON_RATE:     r_moon_cfg.rate     <= i_cfg_data[RATE_W-1:0];
                default: ;
            endcase
        end
    end

    // Pipeline control
    logic               w_adv;
    logic               w_take;
    logic               w_out_fire;
    logic [LANE_LAT-1:0] r_vld;
    logic               r_ser_valid;
    t_body              r_body;
    t_body              n_body;
    logic               n_ser_valid;

    assign w_out_fire = o_out.valid && o_out.ready;
    assign w_take     = r_vld[TAIL] &&
                        (!r_ser_valid || (w_out_fire && r_body == BODY_MOON));
    assign w_adv      = !r_vld[TAIL] || w_take;
    assign i_in.ready = w_adv;

    // Advance the valid bits with the lane data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[LANE_LAT-2:0], i_in.valid};
        end
    end

    // Orbit lanes
    t_orbit w_planet;
    t_orbit w_moon;

    tlco_orbit_lane u_planet (
        .i_clk   (i_clk),
        .i_adv   (w_adv),
        .i_time  (i_in.elapsed_time),
        .i_cfg   (r_planet_cfg),
        .o_orbit (w_planet)
    );

    tlco_orbit_lane u_moon (
        .i_clk   (i_clk),
        .i_adv   (w_adv),
        .i_time  (i_in.elapsed_time),
        .i_cfg   (r_moon_cfg),
        .o_orbit (w_moon)
    );

    // Output register: planet result and moon offset by the planet.
    // Lane values are far inside the field ranges, so widening never clips.
    t_result r_pl_res;
    t_result r_mo_res;

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_pl_res.pos_x <= POS_W'(w_planet.pos_x);
            r_pl_res.pos_y <= POS_W'(w_planet.pos_y);
            r_pl_res.vel_x <= VEL_W'(w_planet.vel_x);
            r_pl_res.vel_y <= VEL_W'(w_planet.vel_y);
            r_mo_res.pos_x <= POS_W'(w_planet.pos_x) + POS_W'(w_moon.pos_x);
            r_mo_res.pos_y <= POS_W'(w_planet.pos_y) + POS_W'(w_moon.pos_y);
            r_mo_res.vel_x <= VEL_W'(w_planet.vel_x) + VEL_W'(w_moon.vel_x);
            r_mo_res.vel_y <= VEL_W'(w_planet.vel_y) + VEL_W'(w_moon.vel_y);
        end
    end

    // Result sequencer: next state
    always_comb begin
        n_ser_valid = r_ser_valid;
        n_body      = r_body;
        if (w_take) begin
            n_ser_valid = 1'b1;
            n_body      = BODY_SUN;
        end else if (w_out_fire) begin
            case (r_body)
                BODY_SUN:    n_body = BODY_PLANET;
                BODY_PLANET: n_body = BODY_MOON;
                BODY_MOON:   n_ser_valid = 1'b0;
                default:     n_ser_valid = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ser_valid <= 1'b0;
            r_body      <= BODY_SUN;
        end else begin
            r_ser_valid <= n_ser_valid;
            r_body      <= n_body;
        end
    end

    // Result sequencer: outputs
    always_comb begin
        o_out.valid = r_ser_valid;
        o_out.body  = r_body;
        o_out.pos_x = '0;
        o_out.pos_y = '0;
        o_out.vel_x = '0;
        o_out.vel_y = '0;
        o_out.last  = 1'b0;
        case (r_body)
            BODY_SUN: ;
            BODY_PLANET: begin
                o_out.pos_x = r_pl_res.pos_x;
                o_out.pos_y = r_pl_res.pos_y;
                o_out.vel_x = r_pl_res.vel_x;
                o_out.vel_y = r_pl_res.vel_y;
            end
            BODY_MOON: begin
                o_out.pos_x = r_mo_res.pos_x;
                o_out.pos_y = r_mo_res.pos_y;
                o_out.vel_x = r_mo_res.vel_x;
                o_out.vel_y = r_mo_res.vel_y;
                o_out.last  = 1'b1;
            end
            default: ;
        endcase
    end

    // A full tail that is not taken blocks new items
    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[TAIL] && !w_take |-> !i_in.ready)
        else $error("input ready while the pipeline tail is stalled");

    // A stalled tail item is kept for the next cycle
    a_tail_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[TAIL] && !w_adv |=> r_vld[TAIL])
        else $error("pipeline tail item lost during a stall");

    // Sun and planet are followed by the next body of the same item
    a_body_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_fire && !o_out.last |=>
            o_out.valid && o_out.body == 2'($past(o_out.body) + 2'd1))
        else $error("result items out of body order");

    // After the moon item, either a new item starts at the sun or output idles
    a_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_fire && o_out.last && !w_take |=> !o_out.valid)
        else $error("result shown after the last item without a new item");

endmodule

[hdl/tlco_orbit_lane.sv]
module tlco_orbit_lane import tlco_pkg::*; (
    input  logic              i_clk,
    input  logic              i_adv,
    input  logic [TIME_W-1:0] i_time,
    input  t_lane_cfg         i_cfg,
    output t_orbit            o_orbit
);

    localparam int PPOS_W = RAD_W + MAG_W;      // radius times magnitude
    localparam int PHALF  = RAD_W / 2;          // radius split point
    localparam int PPART  = PHALF + MAG_W;      // partial product width
    localparam int PVEL_W = SPD_W + MAG_W;      // speed times magnitude
    localparam int QFRAC  = 30;                 // Q30 fraction bits
    localparam int MPOS_W = PPOS_W - QFRAC;
    localparam int MVEL_W = PVEL_W - QFRAC;

    // Phase products, modulo 2^64, only what reaches the top 32 bits
    logic [2*ANG_W-1:0]   w_ll;
    logic [ANG_W-1:0]     w_hl;
    logic [ANG_W-1:0]     w_lh;
    logic [ANG_W-1:0]     r_p_ll;
    logic [ANG_W-1:0]     r_p_hl;
    logic [ANG_W-1:0]     r_p_lh;

    assign w_ll = i_cfg.rate[ANG_W-1:0] * i_time[ANG_W-1:0];
    assign w_hl = i_cfg.rate[RATE_W-1:ANG_W] * i_time[ANG_W-1:0];
    assign w_lh = i_cfg.rate[ANG_W-1:0] * i_time[TIME_W-1:ANG_W];

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_p_ll <= w_ll[2*ANG_W-1:ANG_W];
            r_p_hl <= w_hl;
            r_p_lh <= w_lh;
        end
    end

    // Angle, half-turn fold and CORDIC start values
    logic [ANG_W-1:0]     w_ang;
    logic                 w_flip;
    logic [ANG_W-1:0]     w_ang_rot;

    assign w_ang     = (r_p_ll + r_p_hl + r_p_lh) & ANGLE_MASK;
    assign w_flip    = w_ang[ANG_W-1] ^ w_ang[ANG_W-2];
    assign w_ang_rot = {w_ang[ANG_W-1] ^ w_flip, w_ang[ANG_W-2:0]};

    logic signed [CW-1:0] r_x    [0:CORDIC_STAGES];
    logic signed [CW-1:0] r_y    [0:CORDIC_STAGES];
    logic signed [CW-1:0] r_z    [0:CORDIC_STAGES];
    logic                 r_flip [0:CORDIC_STAGES];

    // Load the start values, then rotate one step per stage toward zero residual angle
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_x[0]    <= GAIN_Q30;
            r_y[0]    <= '0;
            r_z[0]    <= CW'($signed(w_ang_rot));
            r_flip[0] <= w_flip;
            for (int k = 0; k < CORDIC_STAGES; k++) begin
                if (!r_z[k][CW-1]) begin
                    r_x[k+1] <= r_x[k] - (r_y[k] >>> k);
                    r_y[k+1] <= r_y[k] + (r_x[k] >>> k);
                    r_z[k+1] <= r_z[k] - $signed(CW'(atan_turn(k)));
                end else begin
                    r_x[k+1] <= r_x[k] + (r_y[k] >>> k);
                    r_y[k+1] <= r_y[k] - (r_x[k] >>> k);
                    r_z[k+1] <= r_z[k] + $signed(CW'(atan_turn(k)));
                end
                r_flip[k+1] <= r_flip[k];
            end
        end
    end

    // Undo the fold and split cos and sin into sign and magnitude
    logic signed [CW-1:0] w_cx;
    logic signed [CW-1:0] w_sy;
    logic [CW-1:0]        w_c_abs;
    logic [CW-1:0]        w_s_abs;
    logic [MAG_W-1:0]     r_c_mag;
    logic [MAG_W-1:0]     r_s_mag;
    logic                 r_c_neg;
    logic                 r_s_neg;

    assign w_cx    = r_x[CORDIC_STAGES];
    assign w_sy    = r_y[CORDIC_STAGES];
    assign w_c_abs = w_cx[CW-1] ? CW'(-w_cx) : CW'(w_cx);
    assign w_s_abs = w_sy[CW-1] ? CW'(-w_sy) : CW'(w_sy);

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_c_mag <= w_c_abs[MAG_W-1:0];
            r_s_mag <= w_s_abs[MAG_W-1:0];
            r_c_neg <= w_cx[CW-1] ^ r_flip[CORDIC_STAGES];
            r_s_neg <= w_sy[CW-1] ^ r_flip[CORDIC_STAGES];
        end
    end

    // Multiply on magnitudes; the radius goes in two halves
    logic [PPART-1:0]  r_pxh;
    logic [PPART-1:0]  r_pxl;
    logic [PPART-1:0]  r_pyh;
    logic [PPART-1:0]  r_pyl;
    logic [PVEL_W-1:0] r_vxp;
    logic [PVEL_W-1:0] r_vyp;
    logic              r_m_c_neg;
    logic              r_m_s_neg;

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_pxh     <= i_cfg.radius[RAD_W-1:PHALF] * r_c_mag;
            r_pxl     <= i_cfg.radius[PHALF-1:0] * r_c_mag;
            r_pyh     <= i_cfg.radius[RAD_W-1:PHALF] * r_s_mag;
            r_pyl     <= i_cfg.radius[PHALF-1:0] * r_s_mag;
            r_vxp     <= i_cfg.speed * r_s_mag;
            r_vyp     <= i_cfg.speed * r_c_mag;
            r_m_c_neg <= r_c_neg;
            r_m_s_neg <= r_s_neg;
        end
    end

    // Round to nearest, ties away from zero, on the magnitudes
    localparam logic [PPOS_W-1:0] RND_POS = PPOS_W'(1) << (QFRAC - 1);
    localparam logic [PVEL_W-1:0] RND_VEL = PVEL_W'(1) << (QFRAC - 1);

    logic [PPOS_W-1:0] w_px_sum;
    logic [PPOS_W-1:0] w_py_sum;
    logic [PVEL_W-1:0] w_vx_sum;
    logic [PVEL_W-1:0] w_vy_sum;
    logic [MPOS_W-1:0] r_px_mag;
    logic [MPOS_W-1:0] r_py_mag;
    logic [MVEL_W-1:0] r_vx_mag;
    logic [MVEL_W-1:0] r_vy_mag;
    logic              r_r_c_neg;
    logic              r_r_s_neg;

    assign w_px_sum = (PPOS_W'(r_pxh) << PHALF) + PPOS_W'(r_pxl) + RND_POS;
    assign w_py_sum = (PPOS_W'(r_pyh) << PHALF) + PPOS_W'(r_pyl) + RND_POS;
    assign w_vx_sum = r_vxp + RND_VEL;
    assign w_vy_sum = r_vyp + RND_VEL;

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_px_mag  <= w_px_sum[PPOS_W-1:QFRAC];
            r_py_mag  <= w_py_sum[PPOS_W-1:QFRAC];
            r_vx_mag  <= w_vx_sum[PVEL_W-1:QFRAC];
            r_vy_mag  <= w_vy_sum[PVEL_W-1:QFRAC];
            r_r_c_neg <= r_m_c_neg;
            r_r_s_neg <= r_m_s_neg;
        end
    end

    // Apply signs: velocity is speed times (-sin, cos)
    logic signed [LPOS_W-1:0] w_px_pos;
    logic signed [LPOS_W-1:0] w_py_pos;
    logic signed [LVEL_W-1:0] w_vx_pos;
    logic signed [LVEL_W-1:0] w_vy_pos;
    t_orbit                   r_orbit;

    assign w_px_pos = $signed(LPOS_W'(r_px_mag));
    assign w_py_pos = $signed(LPOS_W'(r_py_mag));
    assign w_vx_pos = $signed(LVEL_W'(r_vx_mag));
    assign w_vy_pos = $signed(LVEL_W'(r_vy_mag));

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_orbit.pos_x <= r_r_c_neg ? -w_px_pos : w_px_pos;
            r_orbit.pos_y <= r_r_s_neg ? -w_py_pos : w_py_pos;
            r_orbit.vel_x <= r_r_s_neg ? w_vx_pos : -w_vx_pos;
            r_orbit.vel_y <= r_r_c_neg ? -w_vy_pos : w_vy_pos;
        end
    end

    assign o_orbit = r_orbit;

endmodule

[tb/sv/orbit_result_checker.sv]
`timescale 1ns / 1ps

module orbit_result_checker import tlco_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    tlco_in_if                    i_in,
    tlco_out_if                   i_out,
    output int                    o_pending,
    output int                    o_fail_count,
    output int                    o_checked
);

    // Q30 CORDIC gain, loaded into x before the first rotation
    localparam longint CORDIC_START = 64'sd652032874;
    localparam longint POS_HI       = 64'sd140737488355327;
    localparam longint VEL_HI       = 64'sd2147483647;

    // Keep the top ANGLE_BITS of the 32 bit turn angle
    localparam logic [31:0] ANGLE_KEEP = ~((32'd1 << (32 - ANGLE_BITS)) - 32'd1);

    // Rotation step angles, atan(2^-i) in 2^-32 turn
    localparam logic [31:0] ARC_STEP [32] = '{
        32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
        32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
        32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051,
        32'h00000028, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000002, 32'h00000001, 32'h00000000, 32'h00000000
    };

    typedef struct {
        t_body                   body;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [VEL_W-1:0] vel_x;
        logic signed [VEL_W-1:0] vel_y;
        logic                    last;
    } t_body_state;

    logic [RAD_W-1:0]  planet_radius;
    logic [SPD_W-1:0]  planet_speed;
    logic [RATE_W-1:0] planet_rate;
    logic [RAD_W-1:0]  moon_radius;
    logic [SPD_W-1:0]  moon_speed;
    logic [RATE_W-1:0] moon_rate;

    t_body_state body_queue[$];
    int          fail_count;
    int          checked_count;

    initial begin
        fail_count    = 0;
        checked_count = 0;
    end

    // Cosine and sine in Q30 of a 32 bit turn angle
    function automatic void turn_to_cos_sin(input logic [31:0] ang,
                                            output longint cos_q, output longint sin_q);
        logic        flip;
        logic [31:0] a;
        longint      x, y, z, dx, dy, step;
        int          i;
        a    = ang;
        flip = (a[31:30] == 2'b01) || (a[31:30] == 2'b10);
        // fold the left half plane onto the right one
        if (flip) begin
            a = a - 32'h80000000;
        end
        z = $signed({{32{a[31]}}, a});
        x = CORDIC_START;
        y = 0;
        for (i = 0; i < CORDIC_STAGES && i < 32; i++) begin
            dx   = y >>> i;
            dy   = x >>> i;
            step = {32'd0, ARC_STEP[i]};
            if (z >= 0) begin
                x = x - dx;
                y = y + dy;
                z = z - step;
            end else begin
                x = x + dx;
                y = y - dy;
                z = z + step;
            end
        end
        cos_q = flip ? -x : x;
        sin_q = flip ? -y : y;
    endfunction

    // Magnitude times Q30 value, rounded half away from zero
    function automatic longint scale_q30(input logic [RAD_W-1:0] mag, input longint q);
        logic [31:0] m;
        logic [95:0] prod;
        longint      r;
        m    = (q < 0) ? 32'(-q) : 32'(q);
        prod = {56'd0, mag} * {64'd0, m};
        prod = prod + (96'd1 << 29);
        r    = longint'(prod >> 30);
        return (q < 0) ? -r : r;
    endfunction

    function automatic longint clamp(input longint v, input longint hi);
        if (v > hi) begin
            return hi;
        end
        if (v < -hi - 1) begin
            return -hi - 1;
        end
        return v;
    endfunction

    // Position and velocity of one body on its circle at time t
    function automatic void orbit_at(input logic [RAD_W-1:0] radius,
                                     input logic [SPD_W-1:0] speed,
                                     input logic [RATE_W-1:0] rate,
                                     input logic [TIME_W-1:0] t,
                                     output longint px, output longint py,
                                     output longint vx, output longint vy);
        logic [63:0] phase;
        logic [31:0] ang;
        longint      c, s;
        phase = rate * {16'd0, t};
        ang   = phase[63:32] & ANGLE_KEEP;
        turn_to_cos_sin(ang, c, s);
        px = scale_q30(radius, c);
        py = scale_q30(radius, s);
        vx = -scale_q30({16'd0, speed}, s);
        vy = scale_q30({16'd0, speed}, c);
    endfunction

    function automatic t_body_state make_body(input t_body b, input longint px,
                                              input longint py, input longint vx,
                                              input longint vy, input logic last);
        t_body_state r;
        r.body  = b;
        r.pos_x = POS_W'(clamp(px, POS_HI));
        r.pos_y = POS_W'(clamp(py, POS_HI));
        r.vel_x = VEL_W'(clamp(vx, VEL_HI));
        r.vel_y = VEL_W'(clamp(vy, VEL_HI));
        r.last  = last;
        return r;
    endfunction

    task automatic flag(input string what);
        fail_count++;
        $error("%s", what);
    endtask

    task automatic check_field(input string field, input logic signed [63:0] want_v,
                               input logic signed [63:0] got_v);
        if (got_v !== want_v) begin
            flag($sformatf("%s: expected %0d, got %0d", field, want_v, got_v));
        end
    endtask

    // Track register writes, predict each accepted time item, compare each result item
    always @(posedge i_clk) begin
        t_body_state want;
        longint      ppx, ppy, pvx, pvy, mpx, mpy, mvx, mvy;
        if (!i_rst_n) begin
            planet_radius = '0;
            planet_speed  = '0;
            planet_rate   = '0;
            moon_radius   = '0;
            moon_speed    = '0;
            moon_rate     = '0;
            body_queue.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_PLANET_RADIUS: planet_radius = i_cfg_data[RAD_W-1:0];
                    CFG_PLANET_SPEED:  planet_speed  = i_cfg_data[SPD_W-1:0];
                    CFG_PLANET_RATE:   planet_rate   = i_cfg_data[RATE_W-1:0];
                    CFG_MOON_RADIUS:   moon_radius   = i_cfg_data[RAD_W-1:0];
                    CFG_MOON_SPEED:    moon_speed    = i_cfg_data[SPD_W-1:0];
                    CFG_MOON_RATE:     moon_rate     = i_cfg_data[RATE_W-1:0];
                    default: ;
                endcase
            end

            if (i_out.valid && i_out.ready) begin
                checked_count++;
                if (body_queue.size() == 0) begin
                    flag($sformatf("result item for body %0d with nothing expected",
                                   i_out.body));
                end else begin
                    want = body_queue.pop_front();
                    check_field("body", want.body, i_out.body);
                    check_field("pos_x", want.pos_x, i_out.pos_x);
                    check_field("pos_y", want.pos_y, i_out.pos_y);
                    check_field("vel_x", want.vel_x, i_out.vel_x);
                    check_field("vel_y", want.vel_y, i_out.vel_y);
                    check_field("last", want.last, i_out.last);
                end
            end

            if (i_in.valid && i_in.ready) begin
                orbit_at(planet_radius, planet_speed, planet_rate, i_in.elapsed_time,
                         ppx, ppy, pvx, pvy);
                orbit_at(moon_radius, moon_speed, moon_rate, i_in.elapsed_time,
                         mpx, mpy, mvx, mvy);
                body_queue.push_back(make_body(BODY_SUN, 0, 0, 0, 0, 1'b0));
                body_queue.push_back(make_body(BODY_PLANET, ppx, ppy, pvx, pvy, 1'b0));
                body_queue.push_back(make_body(BODY_MOON, ppx + mpx, ppy + mpy,
                                               pvx + mvx, pvy + mvy, 1'b1));
            end
        end
        o_pending    <= body_queue.size();
        o_fail_count <= fail_count;
        o_checked    <= checked_count;
    end

endmodule

[tb/sv/two_level_circular_orbit_generator_unit_test.sv]
`timescale 1ns / 1ps

module two_level_circular_orbit_generator_unit_test;
    import tlco_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int DRAIN_CYCLES  = LANE_LAT + 10;
    localparam int RANDOM_PHASES = 5;
    localparam int PHASE_ITEMS   = 38;

    // Indexes the block has no register for
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = 3'd7;

    localparam logic [CFG_IDX_W-1:0] REG_ORDER [6] = '{
        CFG_PLANET_RADIUS, CFG_PLANET_SPEED, CFG_PLANET_RATE,
        CFG_MOON_RADIUS, CFG_MOON_SPEED, CFG_MOON_RATE
    };

    localparam logic [RATE_W-1:0] QUARTER_TURN = 64'h4000_0000_0000_0000;
    localparam logic [RATE_W-1:0] EIGHTH_TURN  = 64'h2000_0000_0000_0000;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    tlco_in_if  in_ch ();
    tlco_out_if out_ch ();

    int pending;
    int fail_count;
    int checked;
    int cycle_count;
    int stall_left;
    int items_sent;
    int settings_used;
    bit calm;

    two_level_circular_orbit_generator_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch.sink),
        .o_out      (out_ch.source)
    );

    orbit_result_checker result_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .o_pending    (pending),
        .o_fail_count (fail_count),
        .o_checked    (checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Stall the result side in bursts of random length
    initial begin
        stall_left = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (calm) begin
                out_ch.ready <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
            end else if ($urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 16) - 1;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // Give up on a hung run
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("FAILURE");
        $finish;
    end

    // Present one time item and hold it until accepted
    task automatic send_time(input logic [TIME_W-1:0] t);
        in_ch.valid        <= 1'b1;
        in_ch.elapsed_time <= t;
        do @(posedge i_clk); while (!in_ch.ready);
        items_sent++;
    endtask

    // Drop valid for a random burst now and then
    task automatic sender_idle();
        if (!calm && $urandom_range(0, 4) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    task automatic end_writes();
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        settings_used++;
    endtask

    // Hold off until every expected result item has come, then let the pipe settle
    task automatic drain();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [TIME_W-1:0] pick_time();
        logic [63:0] raw;
        raw = {$urandom(), $urandom()};
        case ($urandom_range(0, 9))
            0:       return ($urandom_range(0, 1) == 1) ? '1 : '0;
            1, 2, 3: return TIME_W'($urandom_range(0, 4095));
            default: return raw[TIME_W-1:0];
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_reg_value();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return CFG_DATA_W'($urandom_range(0, 1000));
            default: return {$urandom(), $urandom()};
        endcase
    endfunction

    initial begin
        int k;
        int p;
        int n;
        items_sent    = 0;
        settings_used = 1;
        calm          = 1'b0;
        i_rst_n            <= 1'b0;
        i_cfg_we           <= 1'b0;
        i_cfg_idx          <= CFG_PLANET_RADIUS;
        i_cfg_data         <= '0;
        in_ch.valid        <= 1'b0;
        in_ch.elapsed_time <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Registers still at reset: everything sits at the origin
        send_time('0);
        send_time('1);
        send_time(TIME_W'(1));
        drain();

        // Quarter and eighth turn per unit lands on every quadrant boundary;
        // stray bits above each register width and unused indexes must be dropped
        write_reg(CFG_PLANET_RADIUS, {24'hA5C3E1, 40'd149597870700});
        write_reg(CFG_PLANET_SPEED, {40'hF0F0F0F0F0, 24'd7623680});
        write_reg(CFG_PLANET_RATE, QUARTER_TURN);
        write_reg(CFG_MOON_RADIUS, 64'd384400000);
        write_reg(CFG_MOON_SPEED, 64'd261632);
        write_reg(CFG_MOON_RATE, EIGHTH_TURN);
        write_reg(CFG_UNUSED_LO, '1);
        write_reg(CFG_UNUSED_HI, 64'h5A5A_A5A5_0F0F_F0F0);
        end_writes();
        for (k = 0; k <= 8; k++) begin
            send_time(TIME_W'(k));
            sender_idle();
        end
        send_time('1);
        send_time(48'h8000_0000_0000);
        drain();

        // Largest radii and speeds; planet at full rate, moon at zero rate
        write_reg(CFG_PLANET_RADIUS, '1);
        write_reg(CFG_PLANET_SPEED, '1);
        write_reg(CFG_PLANET_RATE, '1);
        write_reg(CFG_MOON_RADIUS, '1);
        write_reg(CFG_MOON_SPEED, '1);
        write_reg(CFG_MOON_RATE, '0);
        end_writes();
        send_time('0);
        send_time(TIME_W'(1));
        send_time('1);
        send_time(48'h8000_0000_0000);
        send_time(TIME_W'(12345));
        drain();

        // Random settings, each followed by a run of random times
        for (p = 0; p < RANDOM_PHASES; p++) begin
            for (k = 0; k < 6; k++) begin
                write_reg(REG_ORDER[k], pick_reg_value());
            end
            if ($urandom_range(0, 1) == 1) begin
                write_reg(($urandom_range(0, 1) == 1) ? CFG_UNUSED_LO : CFG_UNUSED_HI,
                          {$urandom(), $urandom()});
            end
            end_writes();
            calm = (p == RANDOM_PHASES - 1);
            for (n = 0; n < PHASE_ITEMS; n++) begin
                send_time(pick_time());
                if (p == 1 && n == PHASE_ITEMS / 2) begin
                    drain();
                end else begin
                    sender_idle();
                end
            end
            drain();
        end

        $display("Sent %0d time items under %0d register settings; %0d result items checked",
                 items_sent, settings_used, checked);
        $display("with stalls on both channels, a full drain mid-run, and a stall-free tail.");
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

[sim.f]
hdl/tlco_pkg.sv
hdl/tlco_in_if.sv
hdl/tlco_out_if.sv
hdl/tlco_orbit_lane.sv
hdl/two_level_circular_orbit_generator_unit.sv
tb/sv/orbit_result_checker.sv
tb/sv/two_level_circular_orbit_generator_unit_test.sv
